FILE: src/gbn_pkg.sv
package gbn_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int PAYLOAD_BYTES = 20;
    localparam int PAYLOAD_W     = 8 * PAYLOAD_BYTES;
    localparam int SEQ_W         = 32;
    localparam int OUT_SEQ_W     = 31;
    localparam int BSUM_W        = 13;
    localparam int OP_W          = 2;
    localparam int S_TDATA_W     = 3 * SEQ_W + PAYLOAD_W;
    localparam int M_TDATA_W     = 224;
    localparam int WS_W          = 4;
    localparam int TMO_W         = 16;
    localparam int CFG_ADDR_W    = 1;
    localparam int CFG_DATA_W    = 16;

    // Item kinds carried on s_tuser.
    localparam logic [OP_W-1:0] OP_MSG  = 2'd0;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RD,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic msg_send;
        logic ack_take;
        logic tick_dec;
        logic tick_expire;
        logic rd_issue;
        logic retx_emit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            msg_ok;
        logic            ack_ok;
        logic            timer_running;
        logic            timer_expired;
        logic            cnt_zero;
        logic            retx_last;
        logic            out_free;
    } dp_status_t;

    // Sum of the payload bytes taken as signed values.
    function automatic logic [BSUM_W-1:0] byte_sum(input logic [PAYLOAD_W-1:0] p);
        logic [BSUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            s = s + {{(BSUM_W-8){p[8*i+7]}}, p[8*i +: 8]};
        end
        return s;
    endfunction

endpackage

FILE: src/gbn_ctrl.sv
module gbn_ctrl
    import gbn_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (status.op)
                    OP_MSG: begin
                        // A message outside the window is dropped.
                        if (!status.msg_ok) begin
                            state_next = ST_IDLE;
                        end else if (status.out_free) begin
                            cmd.msg_send = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    OP_ACK: begin
                        cmd.ack_take = status.ack_ok;
                        state_next   = ST_IDLE;
                    end
                    OP_TICK: begin
                        state_next = ST_IDLE;
                        if (status.timer_running) begin
                            if (!status.timer_expired) begin
                                cmd.tick_dec = 1'b1;
                            end else begin
                                cmd.tick_expire = 1'b1;
                                if (!status.cnt_zero) begin
                                    state_next = ST_RD;
                                end
                            end
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.retx_emit = 1'b1;
                    state_next    = status.retx_last ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/gbn_datapath.sv
module gbn_datapath
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  dp_cmd_t               cmd,
    output dp_status_t            status
);

    localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int EW    = (CW > WS_W) ? CW : WS_W;
    localparam int TW    = (TIMER_BITS > TMO_W) ? TIMER_BITS : TMO_W;
    localparam int MEM_W = PAYLOAD_W + BSUM_W;
    localparam logic [CW:0]           MW_C = (CW+1)'(MAX_WINDOW);
    localparam logic [SW-1:0]         LAST_SLOT = SW'(MAX_WINDOW - 1);
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    // Configuration registers.
    logic [WS_W-1:0]  ws_reg;
    logic [TMO_W-1:0] tmo_reg;

    // Captured input item.
    logic [OP_W-1:0]      op_reg;
    logic [SEQ_W-1:0]     pseq_reg;
    logic [SEQ_W-1:0]     ack_reg;
    logic [SEQ_W-1:0]     chk_reg;
    logic [PAYLOAD_W-1:0] pay_reg;
    logic [BSUM_W-1:0]    bsum_reg;

    // Window state.
    logic [SEQ_W-1:0]      base_seq_reg, base_seq_next;
    logic [SEQ_W-1:0]      next_seq_reg, next_seq_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [SW-1:0]         base_slot_reg, base_slot_next;
    logic                  tmr_run_reg, tmr_run_next;
    logic [TIMER_BITS-1:0] tmr_cnt_reg, tmr_cnt_next;

    // Retransmit walk.
    logic [SW-1:0]    rd_slot_reg, rd_slot_next;
    logic [SEQ_W-1:0] retx_seq_reg, retx_seq_next;
    logic [CW-1:0]    retx_idx_reg, retx_idx_next;

    // Window memory: payload and its byte sum.
    logic [MEM_W-1:0] mem [MAX_WINDOW];
    logic [MEM_W-1:0] rd_data_reg;

    // Output register.
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_SEQ_W-1:0] out_seq_reg;
    logic [SEQ_W-1:0]     out_chk_reg;
    logic [PAYLOAD_W-1:0] out_pay_reg;
    logic                 out_retx_reg;
    logic                 out_last_reg;

    // Intermediate values.
    logic [EW-1:0]         ws_ext, mw_ext, w_eff;
    logic [CW:0]           wr_sum, adv, new_slot_sum;
    logic [SW-1:0]         wr_slot, new_slot;
    logic [SEQ_W-1:0]      chk_calc, off;
    logic                  chk_ok, off_ok;
    logic [CW-1:0]         new_cnt;
    logic [TW-1:0]         tmo_ext, tmax_ext, t_sat;
    logic [TIMER_BITS-1:0] reload;
    logic                  out_free;
    logic [BSUM_W-1:0]     rd_bsum;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_reg  <= WS_W'(8);
            tmo_reg <= TMO_W'(20);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_WINDOW_SIZE:   ws_reg  <= cfg_wr_data[WS_W-1:0];
                REG_TIMEOUT_TICKS: tmo_reg <= cfg_wr_data[TMO_W-1:0];
                default: ;
            endcase
        end
    end

    // Input capture with the payload byte sum.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= s_tuser;
            pseq_reg <= s_tdata[SEQ_W-1:0];
            ack_reg  <= s_tdata[2*SEQ_W-1:SEQ_W];
            chk_reg  <= s_tdata[3*SEQ_W-1:2*SEQ_W];
            pay_reg  <= s_tdata[S_TDATA_W-1:3*SEQ_W];
            bsum_reg <= byte_sum(s_tdata[S_TDATA_W-1:3*SEQ_W]);
        end
    end

    // Window check and the slot for a new message.
    always_comb begin
        ws_ext  = EW'(ws_reg);
        mw_ext  = EW'(MAX_WINDOW);
        w_eff   = (ws_ext > mw_ext) ? mw_ext : ws_ext;
        wr_sum  = (CW+1)'(base_slot_reg) + (CW+1)'(cnt_reg);
        wr_slot = (wr_sum >= MW_C) ? SW'(wr_sum - MW_C) : SW'(wr_sum);
    end

    // Acknowledgement check and the window advance it causes.
    always_comb begin
        chk_calc     = pseq_reg + ack_reg + {{(SEQ_W-BSUM_W){bsum_reg[BSUM_W-1]}}, bsum_reg};
        chk_ok       = (chk_calc == chk_reg);
        off          = ack_reg - base_seq_reg;
        off_ok       = (off < SEQ_W'(cnt_reg));
        adv          = (CW+1)'(off[CW-1:0]) + (CW+1)'(1);
        new_slot_sum = (CW+1)'(base_slot_reg) + adv;
        new_slot     = (new_slot_sum >= MW_C) ? SW'(new_slot_sum - MW_C) : SW'(new_slot_sum);
        new_cnt      = cnt_reg - adv[CW-1:0];
    end

    // Countdown reload value: saturated to the timer width, at least one.
    always_comb begin
        tmo_ext  = TW'(tmo_reg);
        tmax_ext = TW'(TMAX);
        t_sat    = (tmo_ext > tmax_ext) ? tmax_ext : tmo_ext;
        reload   = (t_sat == '0) ? TIMER_BITS'(1) : t_sat[TIMER_BITS-1:0];
    end

    assign out_free = !out_valid_reg || m_tready;
    assign rd_bsum  = rd_data_reg[MEM_W-1:PAYLOAD_W];

    // Status toward the controller.
    always_comb begin
        status.op            = op_reg;
        status.msg_ok        = (EW'(cnt_reg) < w_eff);
        status.ack_ok        = chk_ok && off_ok;
        status.timer_running = tmr_run_reg;
        status.timer_expired = !(tmr_cnt_reg > TIMER_BITS'(1));
        status.cnt_zero      = (cnt_reg == '0);
        status.retx_last     = (retx_idx_reg == cnt_reg - CW'(1));
        status.out_free      = out_free;
    end

    // Next values of the window, timer and retransmit state.
    always_comb begin
        base_seq_next  = base_seq_reg;
        next_seq_next  = next_seq_reg;
        cnt_next       = cnt_reg;
        base_slot_next = base_slot_reg;
        tmr_run_next   = tmr_run_reg;
        tmr_cnt_next   = tmr_cnt_reg;
        rd_slot_next   = rd_slot_reg;
        retx_seq_next  = retx_seq_reg;
        retx_idx_next  = retx_idx_reg;
        if (cmd.msg_send) begin
            next_seq_next = next_seq_reg + SEQ_W'(1);
            cnt_next      = cnt_reg + CW'(1);
            if (cnt_reg == '0) begin
                tmr_run_next = 1'b1;
                tmr_cnt_next = reload;
            end
        end
        if (cmd.ack_take) begin
            base_seq_next  = ack_reg + SEQ_W'(1);
            cnt_next       = new_cnt;
            base_slot_next = new_slot;
            tmr_run_next   = (new_cnt != '0);
            tmr_cnt_next   = (new_cnt != '0) ? reload : '0;
        end
        if (cmd.tick_dec) begin
            tmr_cnt_next = tmr_cnt_reg - TIMER_BITS'(1);
        end
        if (cmd.tick_expire) begin
            tmr_cnt_next  = reload;
            rd_slot_next  = base_slot_reg;
            retx_seq_next = base_seq_reg;
            retx_idx_next = '0;
        end
        if (cmd.retx_emit) begin
            rd_slot_next  = (rd_slot_reg == LAST_SLOT) ? '0 : rd_slot_reg + SW'(1);
            retx_seq_next = retx_seq_reg + SEQ_W'(1);
            retx_idx_next = retx_idx_reg + CW'(1);
        end
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_seq_reg  <= '0;
            next_seq_reg  <= '0;
            cnt_reg       <= '0;
            base_slot_reg <= '0;
            tmr_run_reg   <= 1'b0;
            tmr_cnt_reg   <= '0;
            rd_slot_reg   <= '0;
            retx_seq_reg  <= '0;
            retx_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            base_seq_reg  <= base_seq_next;
            next_seq_reg  <= next_seq_next;
            cnt_reg       <= cnt_next;
            base_slot_reg <= base_slot_next;
            tmr_run_reg   <= tmr_run_next;
            tmr_cnt_reg   <= tmr_cnt_next;
            rd_slot_reg   <= rd_slot_next;
            retx_seq_reg  <= retx_seq_next;
            retx_idx_reg  <= retx_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.msg_send) begin
            mem[wr_slot] <= {bsum_reg, pay_reg};
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_slot_reg];
        end
    end

    // Output register: a first send or a resend from memory.
    assign out_valid_next = cmd.msg_send || cmd.retx_emit || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (cmd.msg_send) begin
            out_seq_reg  <= next_seq_reg[OUT_SEQ_W-1:0];
            out_chk_reg  <= next_seq_reg
                          + {{(SEQ_W-BSUM_W){bsum_reg[BSUM_W-1]}}, bsum_reg};
            out_pay_reg  <= pay_reg;
            out_retx_reg <= 1'b0;
            out_last_reg <= 1'b1;
        end else if (cmd.retx_emit) begin
            out_seq_reg  <= retx_seq_reg[OUT_SEQ_W-1:0];
            out_chk_reg  <= retx_seq_reg
                          + {{(SEQ_W-BSUM_W){rd_bsum[BSUM_W-1]}}, rd_bsum};
            out_pay_reg  <= rd_data_reg[PAYLOAD_W-1:0];
            out_retx_reg <= 1'b1;
            out_last_reg <= status.retx_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_pay_reg, out_chk_reg, out_seq_reg};
    assign m_tuser  = out_retx_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: src/go_back_n_sender_top.sv
// Go-Back-N sender. Each input transaction is a new 20-byte message, an arriving
// acknowledgement packet or a timer tick (s_tuser). Messages inside the window are
// sent at once and kept for resending; acks with a good checksum and a number inside
// the outstanding range release packets up to the acked number; on countdown expiry
// every outstanding packet is sent again, oldest first, with m_tuser set and m_tlast
// on the final one. Each input is captured, then executed, before the next is
// accepted; a message also waits while the single output register still holds an
// untaken result. On expiry each resend is a window memory read, then an output
// register load. Configuration is written through cfg_wr_en/cfg_addr/cfg_wr_data;
// the user must do so only while idle, as the block itself does not enforce it.
module go_back_n_sender_top
    import gbn_pkg::*;
#(
    parameter int MAX_WINDOW = 8,
    parameter int TIMER_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // pkt_seq[31:0], ack_number[63:32], packet_checksum[95:64],
    // payload_low[159:96], payload_mid[223:160], payload_high[255:224]
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // operation[1:0]
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_seq[30:0], out_checksum[62:31], out_payload_low[126:63],
    // out_payload_mid[190:127], out_payload_high[222:191], zero[223]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // is_retransmit
    output logic                  m_tuser,
    output logic                  m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;

    gbn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gbn_datapath #(
        .MAX_WINDOW (MAX_WINDOW),
        .TIMER_BITS (TIMER_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

FILE: src/gbn_checker.sv
module gbn_checker
    import gbn_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [OP_W-1:0]      s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // A stalled result transaction keeps its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A first send is always the only result of its input.
    a_first_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("first send without last");

    // Every accepted input passes through execute before the next is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken in back-to-back cycles");

    // An ack or an unused kind never stalls the input side.
    a_ack_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != OP_MSG && s_tuser != OP_TICK) |=> ##1 s_tready)
        else $error("ack did not return to ready");

endmodule

bind go_back_n_sender_top gbn_checker u_gbn_checker (.*);

FILE: tb/gbn_sender_checker.sv
`timescale 1ns / 1ps

// Shared helpers for the sender's testbench.
package gbn_tb_pkg;

    import gbn_pkg::*;

    // Item kind that the sender does not use and must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Sum of the 20 payload bytes, each taken as a signed value, modulo 2^32.
    function automatic logic [31:0] payload_sum(input logic [PAYLOAD_W-1:0] p);
        logic [31:0] total;
        total = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            total += {{24{p[8*i+7]}}, p[8*i +: 8]};
        end
        return total;
    endfunction

endpackage

// Watches both stream channels and the configuration port, keeps its own copy of
// the sender's window and countdown, and checks every packet sent to the network.
module gbn_sender_checker
    import gbn_pkg::*;
    import gbn_tb_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  m_tuser,
    input  logic                  m_tlast,
    output int                    mismatches,
    output int                    pending_pkts,
    output logic [31:0]           seq_base,
    output logic [31:0]           seq_next
);

    typedef struct packed {
        logic [OUT_SEQ_W-1:0] seq;
        logic [31:0]          csum;
        logic [PAYLOAD_W-1:0] payload;
        logic                 retx;
        logic                 last;
    } net_pkt_t;

    // Packets the sender owes the network, oldest first.
    net_pkt_t pending_sends[$];

    // Sender state as predicted.
    logic [31:0]          base_seq_q;
    logic [31:0]          next_seq_q;
    logic                 timer_on;
    logic [31:0]          timer_left;
    int                   head_slot;
    logic [PAYLOAD_W-1:0] slot_payload [SLOTS];
    logic [WS_W-1:0]      win_cfg;
    logic [TMO_W-1:0]     tmo_cfg;

    initial begin
        mismatches   = 0;
        pending_pkts = 0;
        seq_base     = '0;
        seq_next     = '0;
    end

    function automatic logic [31:0] reload_ticks();
        return (tmo_cfg == 0) ? 32'd1 : 32'(tmo_cfg);
    endfunction

    task automatic queue_send(logic [31:0] seq, logic [PAYLOAD_W-1:0] body,
                              logic retx, logic last);
        net_pkt_t pkt;
        pkt.seq     = seq[OUT_SEQ_W-1:0];
        pkt.csum    = seq + payload_sum(body);
        pkt.payload = body;
        pkt.retx    = retx;
        pkt.last    = last;
        pending_sends.push_back(pkt);
    endtask

    task automatic flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    task automatic compare_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            flag_mismatch(what, want, got);
        end
    endtask

    // Check one packet leaving on the master side against the oldest prediction.
    task automatic check_sent_packet();
        net_pkt_t exp_pkt;
        if (pending_sends.size() == 0) begin
            flag_mismatch("unexpected packet, seq", '0, 64'(m_tdata[30:0]));
            return;
        end
        exp_pkt = pending_sends.pop_front();
        compare_field("out_seq", 64'(exp_pkt.seq), 64'(m_tdata[30:0]));
        compare_field("out_checksum", 64'(exp_pkt.csum), 64'(m_tdata[62:31]));
        compare_field("out_payload_low", exp_pkt.payload[63:0], m_tdata[126:63]);
        compare_field("out_payload_mid", exp_pkt.payload[127:64], m_tdata[190:127]);
        compare_field("out_payload_high", 64'(exp_pkt.payload[159:128]),
                      64'(m_tdata[222:191]));
        compare_field("is_retransmit", 64'(exp_pkt.retx), 64'(m_tuser));
        compare_field("last", 64'(exp_pkt.last), 64'(m_tlast));
    endtask

    // Apply one accepted input item to the predicted sender state.
    task automatic advance_sender(logic [OP_W-1:0] kind, logic [S_TDATA_W-1:0] data);
        logic [31:0]          in_flight;
        logic [31:0]          win_eff;
        logic [31:0]          ack_no;
        logic [31:0]          lag;
        logic [31:0]          sum_chk;
        logic [PAYLOAD_W-1:0] body;
        int                   n;
        in_flight = next_seq_q - base_seq_q;
        body      = data[S_TDATA_W-1 -: PAYLOAD_W];
        ack_no    = data[63:32];
        case (kind)
            OP_MSG: begin
                win_eff = (win_cfg > SLOTS) ? 32'(SLOTS) : 32'(win_cfg);
                if (in_flight < win_eff) begin
                    slot_payload[(head_slot + in_flight) % SLOTS] = body;
                    queue_send(next_seq_q, body, 1'b0, 1'b1);
                    // The countdown starts with the first outstanding packet.
                    if (in_flight == 0) begin
                        timer_on   = 1'b1;
                        timer_left = reload_ticks();
                    end
                    next_seq_q++;
                end
            end
            OP_ACK: begin
                sum_chk = data[31:0] + ack_no + payload_sum(body);
                lag     = ack_no - base_seq_q;
                // Only a good checksum inside the outstanding range is taken.
                if (sum_chk == data[95:64] && lag < in_flight) begin
                    head_slot  = (head_slot + lag + 1) % SLOTS;
                    base_seq_q = ack_no + 1;
                    timer_on   = 1'b0;
                    timer_left = '0;
                    if (base_seq_q != next_seq_q) begin
                        timer_on   = 1'b1;
                        timer_left = reload_ticks();
                    end
                end
            end
            OP_TICK: begin
                if (timer_on) begin
                    if (timer_left > 1) begin
                        timer_left--;
                    end else begin
                        // Expiry: reload and resend the whole window, oldest first.
                        timer_left = reload_ticks();
                        n = (in_flight > SLOTS) ? SLOTS : int'(in_flight);
                        for (int i = 0; i < n; i++) begin
                            queue_send(base_seq_q + i, slot_payload[(head_slot + i) % SLOTS],
                                       1'b1, i == n - 1);
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            base_seq_q = '0;
            next_seq_q = '0;
            timer_on   = 1'b0;
            timer_left = '0;
            head_slot  = 0;
            win_cfg    = 4'd8;
            tmo_cfg    = 16'd20;
            pending_sends.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_WINDOW_SIZE:   win_cfg = cfg_wr_data[WS_W-1:0];
                    REG_TIMEOUT_TICKS: tmo_cfg = cfg_wr_data[TMO_W-1:0];
                    default: ;
                endcase
            end
            // Results leaving now stem from earlier inputs, so check them first.
            if (m_tvalid && m_tready) begin
                check_sent_packet();
            end
            if (s_tvalid && s_tready) begin
                advance_sender(s_tuser, s_tdata);
            end
        end
        pending_pkts <= pending_sends.size();
        seq_base     <= base_seq_q;
        seq_next     <= next_seq_q;
    end

endmodule

FILE: tb/tb_go_back_n_sender_top.sv
`timescale 1ns / 1ps

module tb_go_back_n_sender_top;

    import gbn_pkg::*;
    import gbn_tb_pkg::*;

    // Far above the slowest correct run, including full-window resends under stalls.
    localparam int LIMIT_CYCLES = 300000;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    logic [OP_W-1:0]       s_tuser     = '0;
    logic                  m_tready    = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    int          mismatches;
    int          pending_pkts;
    logic [31:0] seq_base;
    logic [31:0] seq_next;
    int          send_gap_pct = 0;
    int          stall_pct    = 0;
    int          cycle_cnt    = 0;

    always #6 aclk = ~aclk;

    go_back_n_sender_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    gbn_sender_checker u_sender_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .mismatches   (mismatches),
        .pending_pkts (pending_pkts),
        .seq_base     (seq_base),
        .seq_next     (seq_next)
    );

    // The network side stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES) begin
            $display("go_back_n_sender_top: mismatch");
            $finish;
        end
    end

    function automatic logic [PAYLOAD_W-1:0] rand_payload();
        return {$urandom, $urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic logic [S_TDATA_W-1:0] rand_item_data();
        return {rand_payload(), $urandom, $urandom, $urandom};
    endfunction

    // Offer one item, with random idle cycles first, and return once it is taken.
    task automatic put_item(logic [OP_W-1:0] kind, logic [S_TDATA_W-1:0] data);
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_message(logic [PAYLOAD_W-1:0] body);
        put_item(OP_MSG, {body, $urandom, $urandom, $urandom});
    endtask

    task automatic send_tick();
        put_item(OP_TICK, rand_item_data());
    endtask

    // Ack packet with a correct checksum, or one bit of it flipped when corrupt.
    task automatic send_ack(logic [31:0] pkt_seq, logic [31:0] ack_no,
                            logic [PAYLOAD_W-1:0] body, bit corrupt);
        logic [31:0] chk;
        chk = pkt_seq + ack_no + payload_sum(body);
        if (corrupt) begin
            chk = chk ^ (32'd1 << $urandom_range(31));
        end
        put_item(OP_ACK, {body, chk, ack_no, pkt_seq});
    endtask

    // Stop sending until every predicted packet is out and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_pkts != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic set_config(logic [WS_W-1:0] ws, logic [TMO_W-1:0] ticks);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_WINDOW_SIZE;
        cfg_wr_data <= CFG_DATA_W'(ws);
        @(posedge aclk);
        cfg_addr    <= REG_TIMEOUT_TICKS;
        cfg_wr_data <= ticks;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // Mostly well-formed traffic: messages, acks inside the window and ticks,
    // with some corrupt, stale, future and unused-kind items mixed in.
    task automatic random_item();
        int          pick;
        logic [31:0] span;
        logic [31:0] target;
        pick = $urandom_range(99);
        span = seq_next - seq_base;
        if (pick < 40) begin
            send_message(rand_payload());
        end else if (pick < 62) begin
            target = (span == 0) ? seq_base - 1 : seq_base + $urandom_range(span - 1);
            send_ack($urandom, target, rand_payload(), 1'b0);
        end else if (pick < 88) begin
            send_tick();
        end else begin
            case (pick % 4)
                0: send_ack($urandom, seq_base + $urandom_range(7), rand_payload(), 1'b1);
                1: send_ack($urandom, $urandom, rand_payload(), 1'b0);
                2: put_item(OP_UNUSED, rand_item_data());
                default: send_ack($urandom, seq_next + $urandom_range(3), rand_payload(),
                                  1'b0);
            endcase
        end
    endtask

    task automatic run_phase(logic [WS_W-1:0] ws, logic [TMO_W-1:0] ticks,
                             int gap, int stall, int count);
        set_config(ws, ticks);
        send_gap_pct = gap;
        stall_pct    = stall;
        repeat (count) random_item();
        settle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: window of 8, short countdown.
        set_config(4'd8, 16'd2);
        send_tick();                                        // countdown stopped
        put_item(OP_UNUSED, rand_item_data());
        send_ack(32'd0, 32'd0, rand_payload(), 1'b0);       // nothing outstanding
        send_message({20{8'h00}});
        send_message({20{8'hFF}});
        send_message({20{8'h80}});
        send_message({20{8'h7F}});
        send_message({10{16'hAA55}});
        send_message(rand_payload());
        send_message(rand_payload());
        send_message(rand_payload());
        send_message(rand_payload());                       // window full, dropped
        send_ack(32'd5, 32'd3, rand_payload(), 1'b1);       // bad checksum
        send_ack(32'h8000_0000, 32'd2, {20{8'h80}}, 1'b0);  // releases 0 to 2
        send_ack(32'h7FFF_FFFF, 32'd1, {20{8'h7F}}, 1'b0);  // stale
        send_ack(32'hFFFF_FFFF, 32'd8, {20{8'hFF}}, 1'b0);  // beyond next
        send_tick();
        send_tick();                                        // expiry resends 3 to 7
        send_ack(32'd0, 32'd7, rand_payload(), 1'b0);       // releases all, timer stops
        send_tick();
        settle();

        // A window of zero accepts nothing.
        set_config(4'd0, 16'd0);
        send_message(rand_payload());
        settle();

        // A window above the slot count acts as full size; a zero timeout as one tick.
        set_config(4'd12, 16'd0);
        send_message(rand_payload());
        send_tick();
        send_ack($urandom, 32'd8, rand_payload(), 1'b0);
        settle();

        // Random traffic under several settings and idling patterns.
        run_phase(4'd8, 16'd3, 0, 0, 30);
        run_phase(4'd4, 16'd2, 69, 0, 30);
        run_phase(4'd1, 16'd1, 0, 69, 30);
        run_phase(4'd8, 16'd5, 23, 23, 30);
        run_phase(4'd6, 16'hFFFF, 0, 0, 15);
        run_phase(4'd8, 16'd2, 23, 23, 15);

        if (mismatches == 0) begin
            $display("go_back_n_sender_top: match");
        end else begin
            $display("go_back_n_sender_top: mismatch");
        end
        $finish;
    end

endmodule
